>>> rtl/slab_header_allocator_core_macros.svh
// Assertion macros used by the checker file of the slab header allocator.
`ifndef SLAB_HEADER_ALLOCATOR_CORE_MACROS_SVH
`define SLAB_HEADER_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SHA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slab header allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slab header allocator: next-cycle check failed");

`endif

>>> rtl/sha_pkg.sv
`default_nettype none

package sha_pkg;

    // Pool geometry.
    localparam int SLAB_CAPACITY = 64;
    localparam int MAX_SLABS     = 16;
    localparam int STACK_DEPTH   = 1024;
    localparam int HANDLE_SPACE  = 1024;

    // Field and state widths.
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int LIMIT_W  = 5;
    localparam int SLOT_W   = 7;
    localparam int STACK_AW = 10;
    localparam int WIDE_W   = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    // Request operation codes.
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_FREE  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic commit;
    } t_ctrl_cmd;

endpackage

`default_nettype wire

>>> rtl/sha_req_if.sv
`default_nettype none

interface sha_req_if import sha_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [HANDLE_W-1:0] handle_in;

    modport source (output valid, output cmd, output handle_in, input ready);
    modport sink   (input valid, input cmd, input handle_in, output ready);
endinterface

`default_nettype wire

>>> rtl/sha_rsp_if.sv
`default_nettype none

interface sha_rsp_if import sha_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] handle_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  live_count;

    modport source (output valid, output handle_out, output status, output live_count,
                    input ready);
    modport sink   (input valid, input handle_out, input status, input live_count,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/sha_ctrl.sv
`default_nettype none

module sha_ctrl import sha_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   commit;

    // A request is taken only in idle; the result commits once the output slot is free.
    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output register is filled on commit and emptied when the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.commit = commit;

endmodule

`default_nettype wire

>>> rtl/sha_dpath.sv
`default_nettype none

module sha_dpath import sha_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctrl_cmd           i_cmd,
    input  wire logic                i_cfg_we,
    input  wire logic [LIMIT_W-1:0]  i_cfg_data,
    input  wire logic                i_req_cmd,
    input  wire logic [HANDLE_W-1:0] i_req_handle,
    output logic [HANDLE_W-1:0]      o_handle_out,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_live_count
);

    // Free stack storage and its registered read port.
    logic [HANDLE_W-1:0] r_stack [STACK_DEPTH];
    logic [HANDLE_W-1:0] r_rd_data;

    // Allocator state.
    logic [LIMIT_W-1:0]  r_slab_limit;
    logic [COUNT_W-1:0]  r_free_depth;
    logic [COUNT_W-1:0]  n_free_depth;
    logic [LIMIT_W-1:0]  r_slabs_open;
    logic [LIMIT_W-1:0]  n_slabs_open;
    logic [SLOT_W-1:0]   r_next_slot;
    logic [SLOT_W-1:0]   n_next_slot;
    logic [COUNT_W-1:0]  r_live;
    logic [COUNT_W-1:0]  n_live;

    // Captured request.
    logic                r_req_cmd;
    logic [HANDLE_W-1:0] r_req_handle;

    // Result register.
    logic [HANDLE_W-1:0] r_handle_out;
    logic [HANDLE_W-1:0] n_handle_out;
    t_status             r_status;
    t_status             n_status;

    logic [LIMIT_W-1:0]  limit_now;
    logic                need_new;
    logic [LIMIT_W-1:0]  bump_slab;
    logic [SLOT_W-1:0]   bump_slot;
    logic [WIDE_W-1:0]   bump_handle;
    logic [WIDE_W-1:0]   high_water;
    logic [STACK_AW-1:0] rd_addr;
    logic                push;

    // The stack top is read as the request is taken, ready for the execute cycle.
    assign rd_addr = STACK_AW'(r_free_depth - COUNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_stack[rd_addr];
        end
        if (push) begin
            r_stack[r_free_depth[STACK_AW-1:0]] <= r_req_handle;
        end
    end

    // Bump allocation candidate and the high-water mark of handles ever issued.
    always_comb begin
        limit_now   = (r_slab_limit < LIMIT_W'(MAX_SLABS)) ? r_slab_limit
                                                           : LIMIT_W'(MAX_SLABS);
        need_new    = (r_slabs_open == '0) || (r_next_slot >= SLOT_W'(SLAB_CAPACITY));
        bump_slab   = need_new ? r_slabs_open : r_slabs_open - LIMIT_W'(1);
        bump_slot   = need_new ? '0 : r_next_slot;
        bump_handle = WIDE_W'(bump_slab) * WIDE_W'(SLAB_CAPACITY) + WIDE_W'(bump_slot);
        high_water  = (r_slabs_open == '0) ? '0
                    : WIDE_W'(r_slabs_open - LIMIT_W'(1)) * WIDE_W'(SLAB_CAPACITY)
                      + WIDE_W'(r_next_slot);
    end

    // Outcome of the captured request.
    always_comb begin
        n_free_depth = r_free_depth;
        n_slabs_open = r_slabs_open;
        n_next_slot  = r_next_slot;
        n_live       = r_live;
        n_handle_out = '0;
        n_status     = ST_OK;
        push         = 1'b0;
        if (r_req_cmd == CMD_ALLOC) begin
            if (r_free_depth != '0) begin
                n_free_depth = r_free_depth - COUNT_W'(1);
                n_handle_out = r_rd_data;
                n_live       = r_live + COUNT_W'(1);
            end else if ((need_new && (r_slabs_open >= limit_now))
                         || (bump_handle >= WIDE_W'(HANDLE_SPACE))) begin
                n_status = ST_EXHAUSTED;
            end else begin
                if (need_new) begin
                    n_slabs_open = r_slabs_open + LIMIT_W'(1);
                end
                n_next_slot  = bump_slot + SLOT_W'(1);
                n_handle_out = HANDLE_W'(bump_handle);
                n_live       = r_live + COUNT_W'(1);
            end
        end else begin
            if ((r_live == '0) || (WIDE_W'(r_req_handle) >= high_water)
                || (r_free_depth >= COUNT_W'(STACK_DEPTH))) begin
                n_status = ST_BAD_FREE;
            end else begin
                push         = i_cmd.commit;
                n_free_depth = r_free_depth + COUNT_W'(1);
                n_live       = r_live - COUNT_W'(1);
            end
        end
    end

    // Control state: configuration and allocator counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slab_limit <= LIMIT_RESET;
            r_free_depth <= '0;
            r_slabs_open <= '0;
            r_next_slot  <= '0;
            r_live       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_slab_limit <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_free_depth <= n_free_depth;
                r_slabs_open <= n_slabs_open;
                r_next_slot  <= n_next_slot;
                r_live       <= n_live;
            end
        end
    end

    // Payload registers: request capture and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_cmd    <= i_req_cmd;
            r_req_handle <= i_req_handle;
        end
        if (i_cmd.commit) begin
            r_handle_out <= n_handle_out;
            r_status     <= n_status;
            o_live_count <= n_live;
        end
    end

    assign o_handle_out = r_handle_out;
    assign o_status     = r_status;

endmodule

`default_nettype wire

>>> rtl/slab_header_allocator_core.sv
// Slab header allocator.
// Requests arrive on i_req (cmd: allocate or free, handle_in for a free) and each
// produces exactly one response on o_rsp (handle_out, status, live_count).
// Allocation pops the most recently freed handle from a 1024-entry free stack;
// with the stack empty it takes the next slot of the current slab, opening a new
// slab of 64 handles while the slab limit allows.
// Slab limit is written through i_cfg_we / i_cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. The accept step
// reads the stack top from the synchronous stack memory; the execute step computes
// and registers the response. No new request is taken before the last one commits.
// The response register frees the input side: a new request is accepted while a
// response still waits on a stalled receiver; a second response waits in the
// execute step until the register empties, and i_req.ready stays low meanwhile.
// Synchronous active-low reset empties the free stack, closes all slabs, clears
// the live count and sets the slab limit to 16; no clearing pass is needed.
`default_nettype none

module slab_header_allocator_core import sha_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    sha_req_if.sink                 i_req,
    sha_rsp_if.source               o_rsp,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);

    t_ctrl_cmd cmd;

    // Sequencing of request, execute and response hand-off.
    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // Free stack, slab counters and response register.
    sha_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_req_cmd    (i_req.cmd),
        .i_req_handle (i_req.handle_in),
        .o_handle_out (o_rsp.handle_out),
        .o_status     (o_rsp.status),
        .o_live_count (o_rsp.live_count)
    );

endmodule

`default_nettype wire

>>> rtl/sha_checker.sv
`default_nettype none

`include "slab_header_allocator_core_macros.svh"

module sha_checker import sha_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_req_valid,
    input wire logic                i_req_ready,
    input wire logic                i_rsp_valid,
    input wire logic                i_rsp_ready,
    input wire logic [HANDLE_W-1:0] i_handle_out,
    input wire logic [STATUS_W-1:0] i_status,
    input wire logic [COUNT_W-1:0]  i_live_count
);

    // A stalled response keeps its payload.
    `SHA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_handle_out) && $stable(i_status) && $stable(i_live_count))

    // A refused request never carries a handle.
    `SHA_ASSERT_IMPLY(a_fail_no_handle, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_OK), i_handle_out == '0)

    // The live count never exceeds the handle space.
    `SHA_ASSERT_IMPLY(a_live_bound, i_clk, i_rst_n, i_rsp_valid, i_live_count <= COUNT_W'(HANDLE_SPACE))

    // The block is busy for the cycle after it takes a request.
    `SHA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

endmodule

bind slab_header_allocator_core sha_checker u_sha_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_handle_out (o_rsp.handle_out),
    .i_status     (o_rsp.status),
    .i_live_count (o_rsp.live_count)
);

`default_nettype wire

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 200;
    localparam int WELL_FORMED_PCT = 85;

    // One response as the allocator should return it.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        t_status             status;
        logic [COUNT_W-1:0]  live;
    } t_pool_result;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_data;

    sha_req_if req_bus();
    sha_rsp_if rsp_bus();

    slab_header_allocator_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the pool state, updated as each request is accepted.
    logic [HANDLE_W-1:0] free_list [STACK_DEPTH];
    logic [COUNT_W-1:0]  free_top;
    logic [LIMIT_W-1:0]  slabs_opened;
    logic [SLOT_W-1:0]   bump_slot;
    logic [COUNT_W-1:0]  live_total;
    logic [LIMIT_W-1:0]  slab_limit_q;

    t_pool_result        pending_responses[$];
    logic [HANDLE_W-1:0] held_handles[$];
    int                  mismatch_count = 0;
    int                  gap_pct = 0;
    int                  stall_pct = 0;
    int                  quiet_cycles = 0;

    always #(CLK_HALF) clk = ~clk;

    // Works out the response to one request and moves the shadow pool state on.
    function automatic t_pool_result apply_request(input t_cmd op,
                                                   input logic [HANDLE_W-1:0] h);
        t_pool_result res;
        int           limit_eff;
        int           mark;
        int           slab_idx;
        int           slot_idx;
        int           bump;
        logic         new_slab;
        res.handle = '0;
        res.status = ST_OK;
        limit_eff = (int'(slab_limit_q) < MAX_SLABS) ? int'(slab_limit_q) : MAX_SLABS;
        if (op == CMD_ALLOC) begin
            if (free_top != '0) begin
                // The most recently returned handle is reused first.
                free_top   = free_top - COUNT_W'(1);
                res.handle = free_list[free_top[STACK_AW-1:0]];
                live_total = live_total + COUNT_W'(1);
            end else begin
                // Bump allocation; a slab is opened when none is open or the last is full.
                new_slab = (slabs_opened == '0) || (int'(bump_slot) >= SLAB_CAPACITY);
                slab_idx = new_slab ? int'(slabs_opened) : int'(slabs_opened) - 1;
                slot_idx = new_slab ? 0 : int'(bump_slot);
                bump     = slab_idx * SLAB_CAPACITY + slot_idx;
                if ((new_slab && int'(slabs_opened) >= limit_eff) || bump >= HANDLE_SPACE) begin
                    res.status = ST_EXHAUSTED;
                end else begin
                    if (new_slab) begin
                        slabs_opened = slabs_opened + LIMIT_W'(1);
                        bump_slot    = '0;
                    end
                    bump_slot  = bump_slot + SLOT_W'(1);
                    res.handle = HANDLE_W'(bump);
                    live_total = live_total + COUNT_W'(1);
                end
            end
        end else begin
            // A free is refused at or above the bump mark, with none handed out, or with a full list.
            mark = (slabs_opened == '0) ? 0 :
                   (int'(slabs_opened) - 1) * SLAB_CAPACITY + int'(bump_slot);
            if (live_total == '0 || int'(h) >= mark || int'(free_top) >= STACK_DEPTH) begin
                res.status = ST_BAD_FREE;
            end else begin
                free_list[free_top[STACK_AW-1:0]] = h;
                free_top   = free_top + COUNT_W'(1);
                live_total = live_total - COUNT_W'(1);
            end
        end
        res.live = live_total;
        return res;
    endfunction

    // Sends one request, waits for it to be taken and records what must come back.
    task automatic send_request(input t_cmd op, input logic [HANDLE_W-1:0] h);
        t_pool_result res;
        int           idx;
        logic         found;
        while ($urandom_range(0, 99) < gap_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.cmd       <= op;
        req_bus.handle_in <= h;
        do @(posedge clk); while (!req_bus.ready);
        res = apply_request(op, h);
        pending_responses.push_back(res);

        // Keep a list of handles in use so that most frees can be well formed.
        if (res.status == ST_OK) begin
            if (op == CMD_ALLOC) begin
                held_handles.push_back(res.handle);
            end else begin
                found = 1'b0;
                for (idx = 0; idx < held_handles.size() && !found; idx++) begin
                    if (held_handles[idx] == h) begin
                        held_handles.delete(idx);
                        found = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic write_slab_limit(input logic [LIMIT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        slab_limit_q = value;
    endtask

    // Stops sending and waits until every response has come back.
    task automatic drain_responses();
        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly allocations and frees of held handles, with some stray frees mixed in.
    task automatic run_traffic(input int count, input int alloc_pct);
        int                  n;
        int                  pick;
        logic [HANDLE_W-1:0] h;
        for (n = 0; n < count; n++) begin
            h = HANDLE_W'($urandom_range(0, HANDLE_SPACE - 1));
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_request(CMD_ALLOC, h);
            end else if (held_handles.size() != 0 &&
                         $urandom_range(0, 99) < WELL_FORMED_PCT) begin
                pick = $urandom_range(0, held_handles.size() - 1);
                send_request(CMD_FREE, held_handles[pick]);
            end else begin
                send_request(CMD_FREE, h);
            end
        end
    endtask

    // With no slab allowed, nothing can be allocated and nothing can be freed.
    task automatic test_empty_pool();
        write_slab_limit('0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, '0);
        send_request(CMD_FREE, '1);
        drain_responses();
    endtask

    // Bump allocation, frees above and at the mark, and reuse in last-in first-out order.
    task automatic test_bump_and_reuse();
        write_slab_limit(LIMIT_W'(1));
        send_request(CMD_ALLOC, '1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, '1);
        send_request(CMD_FREE, HANDLE_W'(2));
        send_request(CMD_FREE, HANDLE_W'(1));
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, HANDLE_W'(0));
        send_request(CMD_FREE, HANDLE_W'(1));
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '0);
        drain_responses();
    endtask

    // The same handle returned twice is taken twice and handed out twice.
    task automatic test_double_free();
        send_request(CMD_FREE, HANDLE_W'(0));
        send_request(CMD_FREE, HANDLE_W'(0));
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '0);
        drain_responses();
    endtask

    // A limit below the slabs already open still lets the open slab hand out more handles.
    task automatic test_limit_lowered();
        write_slab_limit('0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '1);
        drain_responses();
    endtask

    task automatic test_exhaustion_at_limit();
        gap_pct   = 0;
        stall_pct = 0;
        write_slab_limit(LIMIT_W'(2));
        run_traffic(PHASE_ITEMS, 75);
        drain_responses();
    endtask

    task automatic test_limit_below_open();
        gap_pct   = 51;
        stall_pct = 0;
        write_slab_limit(LIMIT_W'(1));
        run_traffic(PHASE_ITEMS, 50);
        drain_responses();
    endtask

    task automatic test_limit_above_max();
        gap_pct   = 0;
        stall_pct = 51;
        write_slab_limit('1);
        run_traffic(PHASE_ITEMS, 65);
        drain_responses();
    endtask

    task automatic test_full_limit();
        gap_pct   = 18;
        stall_pct = 18;
        write_slab_limit(LIMIT_RESET);
        run_traffic(PHASE_ITEMS, 60);
        drain_responses();
    endtask

    task automatic test_mixed_limits();
        gap_pct   = 0;
        stall_pct = 0;
        write_slab_limit(LIMIT_W'($urandom_range(1, MAX_SLABS)));
        run_traffic(PHASE_ITEMS / 2, 55);
        drain_responses();
        gap_pct   = 18;
        stall_pct = 18;
        write_slab_limit(LIMIT_W'($urandom_range(1, MAX_SLABS)));
        run_traffic(PHASE_ITEMS / 2, 50);
        drain_responses();
    endtask

    // Checks each response against the oldest one still owed.
    always @(posedge clk) begin : rsp_monitor
        t_pool_result want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected response: handle %0d status %0d live %0d",
                             rsp_bus.handle_out, rsp_bus.status, rsp_bus.live_count);
                end
            end else begin
                want = pending_responses.pop_front();
                if (rsp_bus.handle_out !== want.handle || rsp_bus.status !== want.status ||
                    rsp_bus.live_count !== want.live) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("response mismatch: expected handle %0d status %0d live %0d,",
                                 want.handle, want.status, want.live);
                        $display("    got handle %0d status %0d live %0d",
                                 rsp_bus.handle_out, rsp_bus.status, rsp_bus.live_count);
                    end
                end
            end
        end
        rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Ends the run if no request or response moves for too long.
    always @(posedge clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        req_bus.valid     <= 1'b0;
        req_bus.cmd       <= CMD_ALLOC;
        req_bus.handle_in <= '0;
        free_top     = '0;
        slabs_opened = '0;
        bump_slot    = '0;
        live_total   = '0;
        slab_limit_q = LIMIT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pool();
        test_bump_and_reuse();
        test_double_free();
        test_limit_lowered();
        test_exhaustion_at_limit();
        test_limit_below_open();
        test_limit_above_max();
        test_full_limit();
        test_mixed_limits();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_responses.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
